>>> src/prnat_pkg.sv
// shared types and constants for the proxy redirect nat table
package prnat_pkg;
    localparam int unsigned TableEntries = 64;
    localparam logic [15:0] DefaultRedirectPort = 16'd80;

    localparam logic [1:0] ActOutbound = 2'd0;
    localparam logic [1:0] ActInbound  = 2'd1;
    localparam logic [1:0] ActDrop     = 2'd2;

    localparam logic [1:0] RegProxyAddr    = 2'd0;
    localparam logic [1:0] RegProxyPort    = 2'd1;
    localparam logic [1:0] RegRedirectPort = 2'd2;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [15:0] src_port;
        logic [31:0] dst_addr;
        logic [15:0] dst_port;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] new_src_addr;
        logic [15:0] new_src_port;
        logic [31:0] new_dst_addr;
        logic [15:0] new_dst_port;
        logic        lookup_miss;
        logic        table_full;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_DECIDE,
        ST_READV,
        ST_OUT
    } t_state;
endpackage

>>> src/prnat_if.sv
// valid/ready channel interfaces
interface prnat_in_if import prnat_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface prnat_out_if import prnat_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/proxy_redirect_nat_table_core.sv
// proxy redirect nat table top level
//  channel  dir  handshake      payload
//  in       in   valid/ready    src/dst addr and port
//  out      out  valid/ready    action, rewritten tuple, miss/full flags
//  cfg      in   write enable   register index and data
// one word at a time: accept, then a scan of TABLE_ENTRIES entries through the key
// memory (one read per cycle, registered read), then the wait, decide, readv and out
// states finish the compare, write back, read the server memory and load the output
// register. the scan through the single key read port is the longest step for each
// word. valid bits are flip-flops cleared by reset; no clearing pass. a word still
// waiting in the output register holds the next one in its last cycle.
module proxy_redirect_nat_table_core import prnat_pkg::*; #(
    parameter int unsigned TABLE_ENTRIES = TableEntries
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    prnat_in_if.sink    in_ch,
    prnat_out_if.source out_ch,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int unsigned AW = $clog2(TABLE_ENTRIES);

    t_state r_state, n_state;
    logic [31:0] r_proxy_addr;
    logic [15:0] r_proxy_port, r_redirect_port;
    logic [TABLE_ENTRIES-1:0] r_valid;
    t_in_word r_in;
    logic r_outb;
    logic [AW:0] r_idx;
    logic [AW-1:0] r_rd_idx, r_hit_idx, r_free_idx;
    logic r_hit, r_free, r_rd_pend, r_rd_valid;
    logic [47:0] key_rdata, srv_rdata, key_wdata, srv_wdata;
    logic [47:0] w_key;
    logic key_we, srv_we;
    logic [AW-1:0] w_slot;
    t_out_word r_out, n_out;
    logic r_out_valid;

    assign w_key = r_outb ? {r_in.src_addr, r_in.src_port}
                          : {r_in.dst_addr, r_in.dst_port};

    prnat_ram #(.WIDTH(48), .DEPTH(TABLE_ENTRIES)) u_key (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(w_slot), .i_wdata(key_wdata),
        .i_raddr(r_idx[AW-1:0]), .o_rdata(key_rdata));
    prnat_ram #(.WIDTH(48), .DEPTH(TABLE_ENTRIES)) u_srv (
        .i_clk(i_clk), .i_we(srv_we), .i_waddr(w_slot), .i_wdata(srv_wdata),
        .i_raddr(r_hit_idx), .o_rdata(srv_rdata));

    assign w_slot    = r_hit ? r_hit_idx : r_free_idx;
    assign key_wdata = w_key;
    assign srv_wdata = {r_in.dst_addr, r_in.dst_port};
    assign key_we    = (r_state == ST_DECIDE) && r_outb && (r_hit || r_free);
    assign srv_we    = key_we;

    assign in_ch.ready  = (r_state == ST_IDLE) && i_rst_n;
    assign out_ch.valid = r_out_valid;
    assign out_ch.data  = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (in_ch.valid) n_state = ST_SCAN;
            ST_SCAN:   if (r_idx == (AW+1)'(TABLE_ENTRIES - 1)) n_state = ST_WAIT;
            ST_WAIT:   n_state = ST_DECIDE;
            ST_DECIDE: n_state = ST_READV;
            ST_READV:  n_state = ST_OUT;
            ST_OUT:    if (!r_out_valid || out_ch.ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out.action       = ActDrop;
        n_out.new_src_addr = r_in.src_addr;
        n_out.new_src_port = r_in.src_port;
        n_out.new_dst_addr = r_in.dst_addr;
        n_out.new_dst_port = r_in.dst_port;
        n_out.lookup_miss  = 1'b0;
        n_out.table_full   = 1'b0;
        if (r_outb) begin
            n_out.action       = ActOutbound;
            n_out.new_dst_addr = r_proxy_addr;
            n_out.new_dst_port = r_proxy_port;
            n_out.table_full   = !r_hit && !r_free;
        end else if (r_in.src_port == r_proxy_port) begin
            n_out.action = ActInbound;
            if (r_hit) begin
                n_out.new_src_addr = srv_rdata[47:16];
                n_out.new_src_port = srv_rdata[15:0];
            end else begin
                n_out.new_src_addr = '0;
                n_out.new_src_port = '0;
                n_out.lookup_miss  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_proxy_addr    <= '0;
            r_proxy_port    <= '0;
            r_redirect_port <= DefaultRedirectPort;
            r_valid         <= '0;
            r_out_valid     <= 1'b0;
            r_rd_pend       <= 1'b0;
            r_rd_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    RegProxyAddr:    r_proxy_addr <= i_cfg_data;
                    RegProxyPort:    r_proxy_port <= i_cfg_data[15:0];
                    RegRedirectPort: r_redirect_port <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (r_state == ST_OUT && n_state == ST_IDLE) begin
                r_out_valid <= 1'b1;
            end else if (out_ch.valid && out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
            // read data follows the address in the next cycle
            r_rd_pend  <= (r_state == ST_SCAN);
            r_rd_valid <= (r_state == ST_SCAN) && r_valid[r_idx[AW-1:0]];
            if (key_we) r_valid[w_slot] <= 1'b1;
            if (r_state == ST_READV && !r_outb && r_hit &&
                r_in.src_port == r_proxy_port) r_valid[r_hit_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_in   <= in_ch.data;
                r_outb <= (in_ch.data.dst_port == r_redirect_port);
                r_idx  <= '0;
                r_hit  <= 1'b0;
                r_free <= 1'b0;
            end
            ST_SCAN: begin
                r_rd_idx <= r_idx[AW-1:0];
                r_idx    <= r_idx + 1'b1;
                if (!r_free && !r_valid[r_idx[AW-1:0]]) begin
                    r_free     <= 1'b1;
                    r_free_idx <= r_idx[AW-1:0];
                end
            end
            default: ;
        endcase
        if (r_rd_pend && r_rd_valid && !r_hit && key_rdata == w_key) begin
            r_hit     <= 1'b1;
            r_hit_idx <= r_rd_idx;
        end
        if (r_state == ST_OUT && n_state == ST_IDLE) r_out <= n_out;
    end
endmodule

>>> src/prnat_ram.sv
// generic single-port write, registered read ram
module prnat_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
